// ----- hw/rtl/gbp_pkg.sv -----
`default_nettype none

package gbp_pkg;

  // table geometry, field widths, queue depth and counter codes
  localparam int unsigned TABLE_ENTRIES_DEFAULT = 4096;
  localparam int unsigned HIST_W                = 12;
  localparam int unsigned IDX_OUT_W             = 12;
  localparam int unsigned ADDR_W                = 64;
  localparam int unsigned CFG_W                 = 4;
  localparam int unsigned QUEUE_DEPTH_DEFAULT   = 2;

  localparam logic [1:0] CTR_MIN        = 2'd0;
  localparam logic [1:0] CTR_MAX        = 2'd3;
  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;

  // register indexes and reset values
  localparam logic             REG_ADDR_SHIFT     = 1'b0;
  localparam logic             REG_HISTORY_BITS   = 1'b1;
  localparam logic [CFG_W-1:0] ADDR_SHIFT_RESET   = 4'd2;
  localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd12;

  // operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [ADDR_W-1:0]    pc;
    logic [IDX_OUT_W-1:0] update_index;
    logic                 taken;
  } in_item_t;

  typedef struct packed {
    logic                 prediction;
    logic [IDX_OUT_W-1:0] lookup_index;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gshare_branch_predictor.sv -----
`default_nettype none

// channel   direction  handshake         payload
// item      in         push / full       func, pc, update_index, taken
// result    out        pop / empty       prediction, lookup_index
// config    in         cfg_we            cfg_index, cfg_data
//
// front: one transaction a cycle while full is low, into a QUEUE_DEPTH-entry work queue (two by default).
// back: registered table read then counter write-back (updates only) and result push;
// it takes no new transaction until the result of the last one is pushed.
// after the synchronous reset a clearing pass writes one table entry a cycle until
// all TABLE_ENTRIES entries are written, with full held high until it ends.
// a held-off pop fills the result queue, stalls the back and then raises full.

module gshare_branch_predictor #(
  parameter int unsigned TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH   = gbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire gbp_pkg::in_item_t         item,
  input  wire logic                      pop,
  output logic                           empty,
  output gbp_pkg::out_item_t             result,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [gbp_pkg::CFG_W-1:0] cfg_data
);

  import gbp_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned WORK_W = IDX_W + 2;
  localparam int unsigned RES_W  = $bits(out_item_t);

  logic              accept;
  logic [WORK_W-1:0] work_in;
  logic [WORK_W-1:0] work_out;
  logic              work_full;
  logic              work_empty;
  logic              work_pop;
  out_item_t         back_result;
  logic              result_full;
  logic              result_push;
  logic              clearing;
  logic [RES_W-1:0]  result_bits;

  assign full   = work_full || clearing;
  assign accept = push && !full;

  // front: config, history, index
  gbp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .work     (work_in)
  );

  // work queue between front and back
  gbp_fifo #(
    .WIDTH(WORK_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_work_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (accept),
    .wdata(work_in),
    .full (work_full),
    .rd   (work_pop),
    .rdata(work_out),
    .empty(work_empty)
  );

  // back: table read-modify-write
  gbp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (work_out),
    .work_empty (work_empty),
    .work_pop   (work_pop),
    .result     (back_result),
    .result_full(result_full),
    .result_push(result_push),
    .clearing   (clearing)
  );

  // result queue
  gbp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (result_push),
    .wdata(back_result),
    .full (result_full),
    .rd   (pop),
    .rdata(result_bits),
    .empty(empty)
  );

  assign result = out_item_t'(result_bits);

`ifndef SYNTHESIS
  // no result can appear while the table is being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> empty)
    else $error("result present during clearing pass");

  // back never takes from an empty work queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    work_pop |-> !work_empty)
    else $error("work queue popped while empty");

  // back never pushes into a full result queue
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    result_push |-> !result_full)
    else $error("result queue pushed while full");

  // the back never takes transactions from the work queue in consecutive cycles
  a_pop_then_push: assert property (@(posedge clk) disable iff (rst)
    work_pop |=> !work_pop)
    else $error("back popped twice without write-back");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gbp_fifo.sv -----
`default_nettype none

module gbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gbp_front.sv -----
`default_nettype none

module gbp_front #(
  parameter int unsigned TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int unsigned IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned WORK_W       = IDX_W + 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [gbp_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      accept,
  input  wire gbp_pkg::in_item_t         item,
  output logic [WORK_W-1:0]              work
);

  import gbp_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

  logic [CFG_W-1:0]  addr_shift;
  logic [CFG_W-1:0]  history_bits;
  logic [HIST_W-1:0] history;
  logic [HIST_W-1:0] history_next;
  logic [HIST_W-1:0] hist_mask;
  logic [ADDR_W-1:0] hash;
  logic [ADDR_W-1:0] upd_ext;
  logic [IDX_W-1:0]  idx;
  logic              is_update;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_shift   <= ADDR_SHIFT_RESET;
      history_bits <= HISTORY_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR_SHIFT:   addr_shift   <= cfg_data;
        REG_HISTORY_BITS: history_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // index: hashed address for a lookup, saved index for an update
  assign is_update = (item.func == FUNC_UPDATE);
  assign hash      = (item.pc >> addr_shift) ^ ADDR_W'(history);
  assign upd_ext   = ADDR_W'(item.update_index);
  assign idx       = (is_update ? upd_ext[IDX_W-1:0] : hash[IDX_W-1:0]) & IDX_MASK;
  assign work      = {is_update, item.taken, idx};

  // history mask, lengths past the register width act as full width
  always_comb begin
    if (history_bits >= CFG_W'(HIST_W)) begin
      hist_mask = '1;
    end else begin
      hist_mask = (HIST_W'(1) << history_bits) - HIST_W'(1);
    end
  end

  assign history_next = {history[HIST_W-2:0], item.taken} & hist_mask;

  // global history moves on each accepted update
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (accept && is_update) begin
      history <= history_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gbp_back.sv -----
`default_nettype none

module gbp_back #(
  parameter int unsigned TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int unsigned IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned WORK_W       = IDX_W + 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORK_W-1:0] work,
  input  wire logic              work_empty,
  output logic                   work_pop,
  output gbp_pkg::out_item_t     result,
  input  wire logic              result_full,
  output logic                   result_push,
  output logic                   clearing
);

  import gbp_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [1:0]       table_mem [TABLE_ENTRIES];
  logic [1:0]       ctr;
  logic [1:0]       ctr_next;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_update;
  logic             cur_taken;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [1:0]       mem_wdata;
  logic [31:0]      idx_wide;

  // sequencer: clearing pass, then read and write-back per transaction
  always_comb begin
    state_next  = state;
    work_pop    = 1'b0;
    result_push = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (!work_empty) begin
          work_pop   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!result_full) begin
          result_push = 1'b1;
          state_next  = S_READ;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  assign clearing = (state == S_CLEAR);

  // transaction held while its counter is read
  always_ff @(posedge clk) begin
    if (work_pop) begin
      {cur_update, cur_taken, cur_idx} <= work;
    end
  end

  // saturating counter step
  always_comb begin
    ctr_next = ctr;
    if (cur_taken) begin
      if (ctr != CTR_MAX) begin
        ctr_next = ctr + 2'd1;
      end
    end else if (ctr != CTR_MIN) begin
      ctr_next = ctr - 2'd1;
    end
  end

  // write port: clearing sweep or counter write-back
  assign mem_we    = clearing || (result_push && cur_update);
  assign mem_waddr = clearing ? clr_idx : cur_idx;
  assign mem_wdata = clearing ? CTR_WEAK_TAKEN : ctr_next;

  // pattern table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (work_pop) begin
      ctr <= table_mem[work[IDX_W-1:0]];
    end
  end

  // result, updates report zeros
  assign idx_wide            = 32'(cur_idx);
  assign result.prediction   = cur_update ? 1'b0 : ctr[1];
  assign result.lookup_index = cur_update ? '0 : idx_wide[IDX_OUT_W-1:0];

endmodule

`default_nettype wire
